[hdl/rgbmx_pkg.sv]
// Shared types, constants and the control program for the RGB matrix scan block.
package rgbmx_pkg;

    // Default geometry and fixed sizes.
    localparam int DEF_ROWS      = 8;
    localparam int DEF_COLUMNS   = 8;
    localparam int GAMMA_REPEATS = 8;
    localparam int GAMMA_W       = 6;

    // Reset values of the current-correction registers.
    localparam logic [GAMMA_W-1:0] GAMMA_RED_RST   = 6'd10;
    localparam logic [GAMMA_W-1:0] GAMMA_GREEN_RST = 6'd63;
    localparam logic [GAMMA_W-1:0] GAMMA_BLUE_RST  = 6'd63;

    // Request codes carried on the input tuser.
    typedef enum logic [2:0] {
        REQ_WRITE = 3'd0,
        REQ_FILL  = 3'd1,
        REQ_SWAP  = 3'd2,
        REQ_SCAN  = 3'd3,
        REQ_GAMMA = 3'd4
    } t_req;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GAMMA_RED   = 2'd0,
        CFG_GAMMA_GREEN = 2'd1,
        CFG_GAMMA_BLUE  = 2'd2
    } t_cfg_idx;

    // Program steps; the step register is the sequencer state.
    typedef enum logic [3:0] {
        ST_CLEAR    = 4'd0,
        ST_IDLE     = 4'd1,
        ST_WRITE    = 4'd2,
        ST_FILL     = 4'd3,
        ST_SWAP     = 4'd4,
        ST_SCAN_RD  = 4'd5,
        ST_SCAN_R   = 4'd6,
        ST_SCAN_G   = 4'd7,
        ST_SCAN_B   = 4'd8,
        ST_SCAN_END = 4'd9,
        ST_GAM_B    = 4'd10,
        ST_GAM_G    = 4'd11,
        ST_GAM_R    = 4'd12
    } t_step;

    // Datapath action of a step.
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_CLEAR   = 3'd1,
        ACT_WRITE   = 3'd2,
        ACT_FILL    = 3'd3,
        ACT_SWAP    = 3'd4,
        ACT_READ    = 3'd5,
        ACT_ROW_ADV = 3'd6
    } t_act;

    // Source of the byte that a step sends; none means the step sends nothing.
    typedef enum logic [2:0] {
        SRC_NONE      = 3'd0,
        SRC_PIX_RED   = 3'd1,
        SRC_PIX_GREEN = 3'd2,
        SRC_PIX_BLUE  = 3'd3,
        SRC_GAM_RED   = 3'd4,
        SRC_GAM_GREEN = 3'd5,
        SRC_GAM_BLUE  = 3'd6
    } t_src;

    // Sequencing: fall through, dispatch on a request, or loop on the shared counter.
    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,
        COND_DISPATCH = 3'd1,
        COND_COL      = 3'd2,
        COND_REP      = 3'd3,
        COND_FILL     = 3'd4,
        COND_CLEAR    = 3'd5
    } t_cond;

    // One control word of the program.
    typedef struct packed {
        t_act  act;
        t_src  src;
        t_cond cond;
        logic  last;
        t_step target;
        t_step follow;
    } t_uword;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        t_step  step;
        t_uword word;
        logic   fire;
        logic   loop_end;
    } t_seq_ctl;

    function automatic t_uword mk_word(input t_act a, input t_src s, input t_cond c,
                                       input logic l, input t_step t, input t_step f);
        t_uword w;
        w = '{act: a, src: s, cond: c, last: l, target: t, follow: f};
        return w;
    endfunction

    // Control store: one word for each step.
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            ST_CLEAR:    w = mk_word(ACT_CLEAR, SRC_NONE, COND_CLEAR, 1'b0, ST_CLEAR, ST_IDLE);
            ST_IDLE:     w = mk_word(ACT_NONE, SRC_NONE, COND_DISPATCH, 1'b0, ST_IDLE, ST_IDLE);
            ST_WRITE:    w = mk_word(ACT_WRITE, SRC_NONE, COND_NEXT, 1'b0, ST_IDLE, ST_IDLE);
            ST_FILL:     w = mk_word(ACT_FILL, SRC_NONE, COND_FILL, 1'b0, ST_FILL, ST_IDLE);
            ST_SWAP:     w = mk_word(ACT_SWAP, SRC_NONE, COND_NEXT, 1'b0, ST_IDLE, ST_IDLE);
            ST_SCAN_RD:  w = mk_word(ACT_READ, SRC_NONE, COND_NEXT, 1'b0, ST_SCAN_R, ST_SCAN_R);
            ST_SCAN_R:   w = mk_word(ACT_NONE, SRC_PIX_RED, COND_NEXT, 1'b0,
                                     ST_SCAN_G, ST_SCAN_G);
            ST_SCAN_G:   w = mk_word(ACT_NONE, SRC_PIX_GREEN, COND_NEXT, 1'b0,
                                     ST_SCAN_B, ST_SCAN_B);
            ST_SCAN_B:   w = mk_word(ACT_NONE, SRC_PIX_BLUE, COND_COL, 1'b1,
                                     ST_SCAN_RD, ST_SCAN_END);
            ST_SCAN_END: w = mk_word(ACT_ROW_ADV, SRC_NONE, COND_NEXT, 1'b0, ST_IDLE, ST_IDLE);
            ST_GAM_B:    w = mk_word(ACT_NONE, SRC_GAM_BLUE, COND_NEXT, 1'b0,
                                     ST_GAM_G, ST_GAM_G);
            ST_GAM_G:    w = mk_word(ACT_NONE, SRC_GAM_GREEN, COND_NEXT, 1'b0,
                                     ST_GAM_R, ST_GAM_R);
            ST_GAM_R:    w = mk_word(ACT_NONE, SRC_GAM_RED, COND_REP, 1'b1,
                                     ST_GAM_B, ST_IDLE);
            default:     w = mk_word(ACT_NONE, SRC_NONE, COND_NEXT, 1'b0, ST_IDLE, ST_IDLE);
        endcase
        return w;
    endfunction

    // Entry step of each request; unused codes leave the sequencer idle.
    function automatic t_step req_entry(input logic [2:0] req);
        t_step s;
        unique case (t_req'(req))
            REQ_WRITE: s = ST_WRITE;
            REQ_FILL:  s = ST_FILL;
            REQ_SWAP:  s = ST_SWAP;
            REQ_SCAN:  s = ST_SCAN_RD;
            REQ_GAMMA: s = ST_GAM_B;
            default:   s = ST_IDLE;
        endcase
        return s;
    endfunction

endpackage

[hdl/rgbmx_seq.sv]
// Program sequencer: step register, shared loop counter and jump logic.
module rgbmx_seq #(
    parameter int ROWS    = rgbmx_pkg::DEF_ROWS,
    parameter int COLUMNS = rgbmx_pkg::DEF_COLUMNS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [2:0]                                   i_req,
    input  logic                                         i_out_free,
    output rgbmx_pkg::t_seq_ctl                          o_ctl,
    output logic [$clog2(ROWS)+$clog2(COLUMNS):0]        o_cnt
);
    import rgbmx_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int CNT_W = 1 + RW + CW;

    t_step             r_step, n_step;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_uword            w_word;
    logic              w_stall;
    logic              w_loop_last;

    // Fetch the control word of the current step.
    assign w_word = ucode(r_step);

    // A sending step waits while the output register is still held.
    assign w_stall = (w_word.src != SRC_NONE) && !i_out_free;

    // Final count of the loop that the current step closes.
    always_comb begin
        case (w_word.cond)
            COND_COL:   w_loop_last = (r_cnt == CNT_W'(COLUMNS - 1));
            COND_REP:   w_loop_last = (r_cnt == CNT_W'(GAMMA_REPEATS - 1));
            COND_FILL:  w_loop_last = (r_cnt == {1'b0, {(CNT_W-1){1'b1}}});
            COND_CLEAR: w_loop_last = (&r_cnt);
            default:    w_loop_last = 1'b1;
        endcase
    end

    // Next step and counter.
    always_comb begin
        n_step = r_step;
        n_cnt  = r_cnt;
        if (!w_stall) begin
            unique case (w_word.cond) inside
                COND_NEXT: begin
                    n_step = w_word.follow;
                end
                COND_DISPATCH: begin
                    if (i_start) begin
                        n_step = req_entry(i_req);
                    end
                end
                COND_COL, COND_REP, COND_FILL, COND_CLEAR: begin
                    if (w_loop_last) begin
                        n_step = w_word.follow;
                        n_cnt  = '0;
                    end else begin
                        n_step = w_word.target;
                        n_cnt  = r_cnt + 1'b1;
                    end
                end
                default: begin
                    n_step = ST_IDLE;
                end
            endcase
        end
    end

    // Control outputs to the datapath.
    always_comb begin
        o_ctl.step     = r_step;
        o_ctl.word     = w_word;
        o_ctl.fire     = !w_stall;
        o_ctl.loop_end = w_loop_last;
        o_cnt          = r_cnt;
    end

    // Step and counter registers; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_CLEAR;
            r_cnt  <= '0;
        end else begin
            r_step <= n_step;
            r_cnt  <= n_cnt;
        end
    end

    // A column loop never leaves the counter beyond the last column.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_word.cond == COND_COL) |-> (r_cnt <= CNT_W'(COLUMNS - 1)))
        else $error("column counter ran past the last column");

    // Dispatch only happens from the idle step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != ST_IDLE) |=> !($past(i_start)) || $past(r_step) == ST_IDLE
            || r_step != req_entry($past(i_req)) || r_step == ST_IDLE
            || $past(w_word.cond) != COND_DISPATCH)
        else $error("request dispatched outside the idle step");

    // A stalled step holds its place.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> (r_step == $past(r_step)) && (r_cnt == $past(r_cnt)))
        else $error("sequencer moved while stalled");

endmodule

[hdl/rgb_matrix_double_buffered_scan.sv]
// Top level: double-buffered RGB frame store with row-scan and gamma word output.
//
//  Channel     | Direction | Handshake                  | Content
//  s_axis      | in        | tvalid / tready            | tuser request code, tdata pixel
//  m_axis      | out       | tvalid / tready            | tdata byte + row, tuser gamma, tlast
//  cfg         | in        | valid / ready (always set) | index, six-bit correction word
//
//  After reset a clearing pass zeroes the whole frame store, both pages; no request is
//  taken meanwhile. A fill writes every pixel of the back page; a scan sends red, green
//  and blue of each column of the current row, and a gamma load sends the blue, green
//  and red words GAMMA_REPEATS times. The output register is one deep, and an output
//  stall holds the program at the sending step.
module rgb_matrix_double_buffered_scan #(
    parameter int ROWS    = rgbmx_pkg::DEF_ROWS,
    parameter int COLUMNS = rgbmx_pkg::DEF_COLUMNS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request input.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: pixel_row[2:0], pixel_column[5:3], red[13:6], green[21:14], blue[29:22]
    input  logic [31:0] i_s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    // Result output.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: data_value[7:0], row_select[10:8]
    output logic [15:0] o_m_axis_tdata,
    // tuser: is_gamma
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);
    import rgbmx_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = 1 + RW + CW;
    localparam int DEPTH = 2 ** AW;

    t_seq_ctl            w_ctl;
    logic [AW-1:0]       w_cnt;
    logic                w_start;
    logic                w_out_free;
    logic                w_emit;

    logic [GAMMA_W-1:0]  r_gamma_red, r_gamma_green, r_gamma_blue;
    logic                r_front;
    logic [RW-1:0]       r_scan_row;
    logic [2:0]          r_prow, r_pcol, r_req;
    logic [23:0]         r_color;

    logic [23:0]         r_frame [DEPTH];
    logic [23:0]         r_rd_data;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [23:0]         w_wdata;
    logic                w_rd;
    logic [AW-1:0]       w_raddr;

    logic [RW+2:0]       w_prow_ext;
    logic [CW+2:0]       w_pcol_ext;
    logic [RW+2:0]       w_scan_ext;
    logic                w_pix_ok;

    logic [7:0]          w_byte;
    logic                w_is_gamma;

    logic                r_out_valid;
    logic [7:0]          r_out_data;
    logic [2:0]          r_out_row;
    logic                r_out_gamma;
    logic                r_out_last;

    // Sequencer.
    rgbmx_seq #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_req      (i_s_axis_tuser),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl),
        .o_cnt      (w_cnt)
    );

    // Request handshake: one request at a time, taken in the idle step.
    assign o_s_axis_tready = (w_ctl.step == ST_IDLE);
    assign w_start         = i_s_axis_tvalid && o_s_axis_tready;

    // Latch the request fields.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_req   <= i_s_axis_tuser;
            r_prow  <= i_s_axis_tdata[2:0];
            r_pcol  <= i_s_axis_tdata[5:3];
            r_color <= {i_s_axis_tdata[13:6], i_s_axis_tdata[21:14], i_s_axis_tdata[29:22]};
        end
    end

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma_red   <= GAMMA_RED_RST;
            r_gamma_green <= GAMMA_GREEN_RST;
            r_gamma_blue  <= GAMMA_BLUE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAMMA_RED:   r_gamma_red   <= i_cfg_data;
                CFG_GAMMA_GREEN: r_gamma_green <= i_cfg_data;
                CFG_GAMMA_BLUE:  r_gamma_blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pixel address of a single write; rows or columns beyond the matrix are dropped.
    assign w_prow_ext = (RW+3)'(r_prow);
    assign w_pcol_ext = (CW+3)'(r_pcol);
    assign w_pix_ok   = (w_prow_ext < (RW+3)'(ROWS)) && (w_pcol_ext < (CW+3)'(COLUMNS))
                        && (t_req'(r_req) == REQ_WRITE);

    // Memory write port: clearing pass, fill of the back page, or one pixel.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_cnt;
        w_wdata = r_color;
        unique case (w_ctl.word.act)
            ACT_CLEAR: begin
                w_we    = w_ctl.fire;
                w_waddr = w_cnt;
                w_wdata = '0;
            end
            ACT_FILL: begin
                w_we    = w_ctl.fire;
                w_waddr = {~r_front, w_cnt[AW-2:0]};
            end
            ACT_WRITE: begin
                w_we    = w_ctl.fire && w_pix_ok;
                w_waddr = {~r_front, w_prow_ext[RW-1:0], w_pcol_ext[CW-1:0]};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Memory read port: the current column of the scanned row in the front page.
    assign w_rd    = (w_ctl.word.act == ACT_READ) && w_ctl.fire;
    assign w_raddr = {r_front, r_scan_row, w_cnt[CW-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_frame[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_rd_data <= r_frame[w_raddr];
        end
    end

    // Page select and scan row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= 1'b0;
            r_scan_row <= '0;
        end else if (w_ctl.fire) begin
            if (w_ctl.word.act == ACT_SWAP) begin
                r_front <= ~r_front;
            end
            if (w_ctl.word.act == ACT_ROW_ADV) begin
                r_scan_row <= (r_scan_row == RW'(ROWS - 1)) ? '0 : r_scan_row + 1'b1;
            end
        end
    end

    // Byte selection for the sending steps.
    always_comb begin
        case (w_ctl.word.src)
            SRC_PIX_RED:   w_byte = r_rd_data[23:16];
            SRC_PIX_GREEN: w_byte = r_rd_data[15:8];
            SRC_PIX_BLUE:  w_byte = r_rd_data[7:0];
            SRC_GAM_RED:   w_byte = 8'(r_gamma_red);
            SRC_GAM_GREEN: w_byte = 8'(r_gamma_green);
            SRC_GAM_BLUE:  w_byte = 8'(r_gamma_blue);
            default:       w_byte = 8'h00;
        endcase
    end

    assign w_is_gamma = (w_ctl.word.src == SRC_GAM_RED) || (w_ctl.word.src == SRC_GAM_GREEN)
                        || (w_ctl.word.src == SRC_GAM_BLUE);
    assign w_scan_ext = (RW+3)'(r_scan_row);

    // Output register; it reloads in the cycle its content is taken.
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_emit     = (w_ctl.word.src != SRC_NONE) && w_ctl.fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data  <= w_byte;
            r_out_gamma <= w_is_gamma;
            r_out_row   <= w_is_gamma ? 3'd0 : w_scan_ext[2:0];
            r_out_last  <= w_ctl.word.last && w_ctl.loop_end;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b00000, r_out_row, r_out_data};
    assign o_m_axis_tuser  = r_out_gamma;
    assign o_m_axis_tlast  = r_out_last;

    // A new byte is only loaded when the previous one has gone or is going.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result overwritten before it was taken");

    // The front page moves only on a swap step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.step != ST_SWAP) |=> $stable(r_front))
        else $error("front page changed outside a swap");

    // The scan row moves only at the end of a scan.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.step != ST_SCAN_END) |=> $stable(r_scan_row))
        else $error("scan row changed outside the end of a scan");

    // Memory writes come only from the clearing, fill and pixel write steps.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_ctl.step == ST_CLEAR) || (w_ctl.step == ST_FILL)
                 || (w_ctl.step == ST_WRITE))
        else $error("frame store written in an unexpected step");

endmodule
